[rtl/mts_pkg.sv]
// shared types and constants for the midi track sequencer
package mts_pkg;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_FETCH  = 5'b00010,
		S_DECODE = 5'b00100,
		S_FIN    = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	typedef enum logic [4:0] {
		PH_DELTA  = 5'b00001,
		PH_STATUS = 5'b00010,
		PH_P1     = 5'b00100,
		PH_P2     = 5'b01000,
		PH_SYSEX  = 5'b10000
	} phase_t;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [2:0] KIND_EVENT   = 3'd1;
	localparam logic [2:0] KIND_LOOPED  = 3'd2;
	localparam logic [2:0] KIND_STOPPED = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [2:0] REG_REVERSE   = 3'd0;
	localparam logic [2:0] REG_MUTE      = 3'd1;
	localparam logic [2:0] REG_LENGTH    = 3'd2;
	localparam logic [2:0] REG_LOOP_MARK = 3'd3;
	localparam logic [2:0] REG_LOOPS     = 3'd4;
	localparam logic [2:0] REG_FADE      = 3'd5;

	localparam logic [7:0] DELTA_PREFIX = 8'hF8;
	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] SYSEX_END    = 8'hF7;
	localparam logic [7:0] LAST_CANCEL  = 8'hF6;
	localparam logic [7:0] END_OF_TRACK = 8'hFC;
	localparam logic [7:0] PAN_CTRL     = 8'd10;
	localparam logic [7:0] PAN_MAX      = 8'h7F;
	localparam logic [16:0] PREFIX_STEP = 17'd240;

	// note-on on a muted channel is dropped
	function automatic logic muted(input logic [7:0] st, input logic [15:0] mask);
		muted = (st[7:4] == 4'h9) && mask[st[3:0]];
	endfunction

endpackage

[rtl/midi_track_sequencer_top.sv]
// midi track sequencer: song memory, event parser and tick player
//
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tuser action, s_tdata address and data
// m_       | out | m_tvalid/m_tready  | m_tuser kind, m_tdata event fields
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// loads and starts are handled in idle; a tick that counts down or plays a held
// event goes back to idle or to the output state; a parsing tick takes each song byte
// through a memory read and a decode, a data byte under running status is read twice,
// then an event is finished and a result is handed over
// a result waits in the output register; a new item is taken while it waits,
// only a tick that makes a further result stalls until the register is free
// reset sets all control state to its defaults; song memory holds garbage until loaded
module midi_track_sequencer_top #(
	parameter int SONG_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[11:0], data[19:12], zero fill
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status_byte, first_param, second_param, loops_left
	output logic [2:0]  m_tuser,   // kind[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(SONG_BYTES);
	// position must hold the memory size and any loop mark
	localparam int PW = (AW + 1 > 13) ? AW + 1 : 13;
	localparam logic [PW-1:0] SONG_BYTES_W = PW'(SONG_BYTES);

	// configuration registers
	logic        reverse_q;
	logic [15:0] mute_q;
	logic [12:0] length_q;
	logic [11:0] loop_mark_q;
	logic [7:0]  loop_count_q;
	logic [15:0] fade_ticks_q;

	// player state
	mts_pkg::state_t state_q;
	mts_pkg::phase_t phase_q;
	logic [PW-1:0] read_pos_q;
	logic [PW-1:0] pos_q;          // working position during a parse
	logic [7:0]    rs_q;
	logic          held_valid_q;
	logic [15:0]   held_delay_q;
	logic [7:0]    held_st_q, held_p1_q, held_p2_q;
	logic signed [16:0] fade_q;
	logic [7:0]    loops_q;
	logic          stopped_q;
	logic [15:0]   delta_q;
	logic [7:0]    st_q, p1_q, p2_q;
	logic          need2_q;

	// pending result
	logic [2:0] res_kind_q;
	logic [7:0] res_st_q, res_p1_q, res_p2_q, res_loops_q;

	// song memory
	logic [7:0] mem [SONG_BYTES];
	logic [7:0] rd_q;

	logic          in_acc;
	logic [1:0]    action;
	logic [16:0]   addr_w;
	logic          mem_we;
	logic [PW-1:0] lim;
	logic [16:0]   dsum;
	logic [15:0]   dsat;
	logic [7:0]    st_v;
	logic [7:0]    loops_dec;
	logic [PW-1:0] pos_nx;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == mts_pkg::S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign action    = s_tuser;
	assign addr_w    = {5'd0, s_tdata[11:0]};
	assign mem_we    = in_acc && (action == mts_pkg::ACT_LOAD)
		&& (32'(addr_w) < 32'(SONG_BYTES));

	// readable bytes, clamped to the memory size
	assign lim = (32'(length_q) >= 32'(SONG_BYTES)) ? SONG_BYTES_W : PW'(length_q);

	// delta accumulation with saturation
	assign dsum = {1'b0, delta_q} + ((rd_q == mts_pkg::DELTA_PREFIX) ?
		mts_pkg::PREFIX_STEP : {9'd0, rd_q});
	assign dsat = dsum[16] ? 16'hFFFF : dsum[15:0];

	// explicit status or running status
	assign st_v      = rd_q[7] ? rd_q : rs_q;
	assign loops_dec = loops_q - 8'd1;
	// position past the status, which only moves for an explicit status byte
	assign pos_nx    = rd_q[7] ? (pos_q + PW'(1)) : pos_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_w[AW-1:0]] <= s_tdata[19:12];
		end
		rd_q <= mem[pos_q[AW-1:0]];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q    <= 1'b0;
			mute_q       <= '0;
			length_q     <= '0;
			loop_mark_q  <= '0;
			loop_count_q <= 8'd1;
			fade_ticks_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mts_pkg::REG_REVERSE:   reverse_q    <= cfg_data[0];
				mts_pkg::REG_MUTE:      mute_q       <= cfg_data;
				mts_pkg::REG_LENGTH:    length_q     <= cfg_data[12:0];
				mts_pkg::REG_LOOP_MARK: loop_mark_q  <= cfg_data[11:0];
				mts_pkg::REG_LOOPS:     loop_count_q <= cfg_data[7:0];
				mts_pkg::REG_FADE:      fade_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			m_tuser  <= '0;
			m_tdata  <= '0;
		end else if (state_q == mts_pkg::S_OUT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
			m_tuser  <= res_kind_q;
			m_tdata  <= {res_loops_q, res_p2_q, res_p1_q, res_st_q};
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mts_pkg::S_IDLE;
			phase_q      <= mts_pkg::PH_DELTA;
			read_pos_q   <= '0;
			pos_q        <= '0;
			rs_q         <= '0;
			held_valid_q <= 1'b0;
			held_delay_q <= '0;
			held_st_q    <= '0;
			held_p1_q    <= '0;
			held_p2_q    <= '0;
			fade_q       <= -17'sd1;
			loops_q      <= 8'd1;
			stopped_q    <= 1'b1;
			delta_q      <= '0;
			st_q         <= '0;
			p1_q         <= '0;
			p2_q         <= '0;
			need2_q      <= 1'b0;
			res_kind_q   <= '0;
			res_st_q     <= '0;
			res_p1_q     <= '0;
			res_p2_q     <= '0;
			res_loops_q  <= '0;
		end else begin
			case (state_q)
				mts_pkg::S_IDLE: begin
					res_st_q    <= '0;
					res_p1_q    <= '0;
					res_p2_q    <= '0;
					res_loops_q <= '0;
					if (in_acc && action == mts_pkg::ACT_START) begin
						read_pos_q   <= '0;
						rs_q         <= '0;
						held_valid_q <= 1'b0;
						held_delay_q <= '0;
						held_st_q    <= '0;
						held_p1_q    <= '0;
						held_p2_q    <= '0;
						fade_q       <= {fade_ticks_q[15], fade_ticks_q};
						loops_q      <= loop_count_q;
						stopped_q    <= 1'b0;
					end else if (in_acc && action == mts_pkg::ACT_TICK && !stopped_q) begin
						if (fade_q == 17'sd0) begin
							// fade ran out
							stopped_q  <= 1'b1;
							res_kind_q <= mts_pkg::KIND_STOPPED;
							state_q    <= mts_pkg::S_OUT;
						end else begin
							if (fade_q > 17'sd0) begin
								fade_q <= fade_q - 17'sd1;
							end
							if (held_valid_q) begin
								if (held_delay_q != '0) begin
									held_delay_q <= held_delay_q - 16'd1;
								end else begin
									held_valid_q <= 1'b0;
									if (!mts_pkg::muted(held_st_q, mute_q)) begin
										res_kind_q <= mts_pkg::KIND_EVENT;
										res_st_q   <= held_st_q;
										res_p1_q   <= held_p1_q;
										res_p2_q   <= held_p2_q;
										state_q    <= mts_pkg::S_OUT;
									end
								end
							end else begin
								pos_q   <= read_pos_q;
								delta_q <= '0;
								p1_q    <= '0;
								p2_q    <= '0;
								phase_q <= mts_pkg::PH_DELTA;
								state_q <= mts_pkg::S_FETCH;
							end
						end
					end
				end
				mts_pkg::S_FETCH: begin
					// memory read of pos_q is under way; overrun ends the parse
					if (pos_q >= lim) begin
						stopped_q  <= 1'b1;
						res_kind_q <= mts_pkg::KIND_ERROR;
						state_q    <= mts_pkg::S_OUT;
					end else begin
						state_q <= mts_pkg::S_DECODE;
					end
				end
				mts_pkg::S_DECODE: begin
					state_q <= mts_pkg::S_FETCH;
					case (phase_q)
						mts_pkg::PH_DELTA: begin
							delta_q <= dsat;
							pos_q   <= pos_q + PW'(1);
							if (rd_q != mts_pkg::DELTA_PREFIX) begin
								phase_q <= mts_pkg::PH_STATUS;
							end
						end
						mts_pkg::PH_STATUS: begin
							st_q <= st_v;
							if (rd_q[7]) begin
								rs_q  <= rd_q;
								pos_q <= pos_q + PW'(1);
							end
							case (st_v[7:4])
								4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
									need2_q <= 1'b1;
									phase_q <= mts_pkg::PH_P1;
								end
								4'hC, 4'hD: begin
									need2_q <= 1'b0;
									phase_q <= mts_pkg::PH_P1;
								end
								4'hF: begin
									if (st_v <= mts_pkg::LAST_CANCEL) begin
										rs_q <= '0;
									end
									if (st_v == mts_pkg::SYSEX_START) begin
										phase_q <= mts_pkg::PH_SYSEX;
									end else if (st_v == mts_pkg::SYSEX_END) begin
										read_pos_q <= pos_nx;
										state_q    <= mts_pkg::S_IDLE;
									end else if (st_v == mts_pkg::END_OF_TRACK) begin
										loops_q <= loops_dec;
										state_q <= mts_pkg::S_OUT;
										if (loops_dec != '0 && loop_mark_q != '0) begin
											read_pos_q  <= PW'(loop_mark_q);
											res_kind_q  <= mts_pkg::KIND_LOOPED;
											res_loops_q <= loops_dec;
										end else begin
											read_pos_q <= pos_nx;
											stopped_q  <= 1'b1;
											res_kind_q <= mts_pkg::KIND_STOPPED;
										end
									end else begin
										// other system status, no data bytes
										state_q <= mts_pkg::S_FIN;
									end
								end
								default: begin
									// running status holds no status
									stopped_q  <= 1'b1;
									res_kind_q <= mts_pkg::KIND_ERROR;
									state_q    <= mts_pkg::S_OUT;
								end
							endcase
						end
						mts_pkg::PH_P1: begin
							p1_q  <= rd_q;
							pos_q <= pos_q + PW'(1);
							if (need2_q) begin
								phase_q <= mts_pkg::PH_P2;
							end else begin
								state_q <= mts_pkg::S_FIN;
							end
						end
						mts_pkg::PH_P2: begin
							pos_q <= pos_q + PW'(1);
							if (reverse_q && st_q[7:4] == 4'hB && p1_q == mts_pkg::PAN_CTRL) begin
								p2_q <= mts_pkg::PAN_MAX - rd_q;
							end else begin
								p2_q <= rd_q;
							end
							state_q <= mts_pkg::S_FIN;
						end
						mts_pkg::PH_SYSEX: begin
							pos_q <= pos_q + PW'(1);
							if (rd_q == mts_pkg::SYSEX_END) begin
								read_pos_q <= pos_q + PW'(1);
								state_q    <= mts_pkg::S_IDLE;
							end
						end
						default: begin
							state_q <= mts_pkg::S_IDLE;
						end
					endcase
				end
				mts_pkg::S_FIN: begin
					read_pos_q <= pos_q;
					if (delta_q != '0) begin
						held_valid_q <= 1'b1;
						held_delay_q <= delta_q;
						held_st_q    <= st_q;
						held_p1_q    <= p1_q;
						held_p2_q    <= p2_q;
						state_q      <= mts_pkg::S_IDLE;
					end else if (mts_pkg::muted(st_q, mute_q)) begin
						state_q <= mts_pkg::S_IDLE;
					end else begin
						res_kind_q <= mts_pkg::KIND_EVENT;
						res_st_q   <= st_q;
						res_p1_q   <= p1_q;
						res_p2_q   <= p2_q;
						state_q    <= mts_pkg::S_OUT;
					end
				end
				mts_pkg::S_OUT: begin
					if (!m_tvalid || m_tready) begin
						state_q <= mts_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mts_pkg::S_IDLE;
				end
			endcase
		end
	end

	// a parse only runs on a playing song
	a_parse_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mts_pkg::S_FETCH || state_q == mts_pkg::S_DECODE) |-> !stopped_q)
		else $error("parse running on a stopped song");

	// a held event and a parse never coexist
	a_held_no_parse: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mts_pkg::S_FETCH) |-> !held_valid_q)
		else $error("parse started while an event is held");

	// a pending result is never dropped by the output register
	a_out_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mts_pkg::S_OUT && (!m_tvalid || m_tready)) |=>
		(m_tvalid && state_q == mts_pkg::S_IDLE))
		else $error("pending result lost");

endmodule
